FILE: design/ilfq_pkg.sv
// ilfq_pkg: shared sizes, codes and structs for the idle-line frame queue
// no dependencies; used via scoped names by all design files but ilfq_ram

package ilfq_pkg;

	localparam int DATA_DEPTH  = 64;
	localparam int FRAME_SLOTS = 8;

	localparam int BYTE_W = 8;
	localparam int REQ_W  = 2;
	localparam int FLEN_W = 6;
	localparam int PTR_W  = $clog2(DATA_DEPTH);
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_BYTE = 2'd0,
		REQ_IDLE = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STREAM,
		ST_EMPTY
	} state_t;

	// one stored frame: length and start offset in the data ring
	typedef struct packed {
		logic [PTR_W-1:0] len;
		logic [PTR_W-1:0] start;
	} desc_t;

	typedef struct packed {
		logic byte_we;
		logic idle_ev;
		logic pop;
	} frame_cmd_t;

	typedef struct packed {
		logic  load;
		logic  empty_rsp;
		desc_t desc;
	} stream_cmd_t;

	typedef struct packed {
		logic busy;
		logic pending;
		logic out_free;
	} stream_sts_t;

endpackage

FILE: design/ilfq_ram.sv
// ilfq_ram: generic single-write, single-read synchronous ram
// registered read data that holds while no read is issued; no dependencies

module ilfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/ilfq_frame_ctl.sv
// ilfq_frame_ctl: write position, frame start and the descriptor slot ring
// depends on ilfq_pkg and ilfq_ram

module ilfq_frame_ctl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ilfq_pkg::frame_cmd_t     cmd,
	output logic [ilfq_pkg::PTR_W-1:0] wr_pos,
	output ilfq_pkg::desc_t          desc,
	output logic                     empty
);

	localparam int PTR_W  = ilfq_pkg::PTR_W;
	localparam int SLOT_W = ilfq_pkg::SLOT_W;
	localparam int CNT_W  = ilfq_pkg::CNT_W;

	logic [PTR_W-1:0]  wr_pos_q;
	logic [PTR_W-1:0]  start_pos_q;
	logic [SLOT_W-1:0] slot_wr_q;
	logic [SLOT_W-1:0] slot_rd_q;
	logic [CNT_W-1:0]  slot_cnt_q;

	logic              push;
	logic              full;
	logic [PTR_W:0]    wrap_len;
	ilfq_pkg::desc_t   new_desc;
	logic [$bits(ilfq_pkg::desc_t)-1:0] rd_raw;

	function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(ilfq_pkg::DATA_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(ilfq_pkg::FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign push  = cmd.idle_ev && (wr_pos_q != start_pos_q);
	assign full  = (slot_cnt_q == CNT_W'(ilfq_pkg::FRAME_SLOTS));
	assign empty = (slot_cnt_q == '0);

	// length of the span from start to write position, wrapping round the ring
	always_comb begin
		if (wr_pos_q > start_pos_q) begin
			wrap_len = {1'b0, wr_pos_q} - {1'b0, start_pos_q};
		end else begin
			wrap_len = (PTR_W + 1)'(ilfq_pkg::DATA_DEPTH) - {1'b0, start_pos_q}
				+ {1'b0, wr_pos_q};
		end
		new_desc.len   = wrap_len[PTR_W-1:0];
		new_desc.start = start_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			start_pos_q <= '0;
			slot_wr_q   <= '0;
			slot_rd_q   <= '0;
			slot_cnt_q  <= '0;
		end else begin
			if (cmd.byte_we) begin
				wr_pos_q <= pos_inc(wr_pos_q);
			end
			if (cmd.idle_ev) begin
				start_pos_q <= wr_pos_q;
			end
			if (push) begin
				slot_wr_q <= slot_inc(slot_wr_q);
				if (full) begin
					// oldest descriptor is overwritten, so the read side moves on too
					slot_rd_q <= slot_inc(slot_rd_q);
				end else begin
					slot_cnt_q <= slot_cnt_q + 1'b1;
				end
			end else if (cmd.pop) begin
				slot_rd_q  <= slot_inc(slot_rd_q);
				slot_cnt_q <= slot_cnt_q - 1'b1;
			end
		end
	end

	ilfq_ram #(
		.WIDTH ($bits(ilfq_pkg::desc_t)),
		.DEPTH (ilfq_pkg::FRAME_SLOTS)
	) u_desc_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (slot_wr_q),
		.wr_data (new_desc),
		.rd_en   (cmd.pop),
		.rd_addr (slot_rd_q),
		.rd_data (rd_raw)
	);

	assign desc   = ilfq_pkg::desc_t'(rd_raw);
	assign wr_pos = wr_pos_q;

endmodule

FILE: design/ilfq_stream.sv
// ilfq_stream: data ring, byte read-out pipeline and the output register
// depends on ilfq_pkg and ilfq_ram

module ilfq_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ilfq_pkg::PTR_W-1:0]      wr_addr,
	input  logic [ilfq_pkg::BYTE_W-1:0]     wr_data,
	input  ilfq_pkg::stream_cmd_t           cmd,
	output ilfq_pkg::stream_sts_t           sts,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [ilfq_pkg::BYTE_W-1:0]     out_byte,
	output logic                            last_byte,
	output logic                            frame_found,
	output logic [ilfq_pkg::FLEN_W-1:0]     frame_length
);

	localparam int PTR_W  = ilfq_pkg::PTR_W;
	localparam int BYTE_W = ilfq_pkg::BYTE_W;
	localparam int FLEN_W = ilfq_pkg::FLEN_W;

	logic [PTR_W-1:0]  rd_addr_q;
	logic [PTR_W-1:0]  remain_q;
	logic [PTR_W-1:0]  len_q;

	logic              valid_s1;
	logic              last_s1;
	logic [PTR_W-1:0]  len_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              found_q;
	logic [FLEN_W-1:0] len_out_q;

	logic out_free;
	logic move_s1;
	logic issue;

	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && out_free;
	// a new ram read may only land when the read data register is free or emptying
	assign issue    = (remain_q != '0) && (!valid_s1 || move_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			remain_q  <= '0;
			len_q     <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			len_s1    <= '0;
		end else begin
			if (cmd.load) begin
				rd_addr_q <= cmd.desc.start;
				remain_q  <= cmd.desc.len;
				len_q     <= cmd.desc.len;
			end else if (issue) begin
				rd_addr_q <= (rd_addr_q == PTR_W'(ilfq_pkg::DATA_DEPTH - 1)) ?
					'0 : rd_addr_q + 1'b1;
				remain_q  <= remain_q - 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
				last_s1  <= (remain_q == PTR_W'(1));
				len_s1   <= len_q;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	ilfq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (ilfq_pkg::DATA_DEPTH)
	) u_data_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr_q),
		.rd_data (byte_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1 || cmd.empty_rsp) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_byte_q <= byte_s1;
			last_q     <= last_s1;
			found_q    <= 1'b1;
			len_out_q  <= FLEN_W'(len_s1);
		end else if (cmd.empty_rsp) begin
			out_byte_q <= '0;
			last_q     <= 1'b1;
			found_q    <= 1'b0;
			len_out_q  <= '0;
		end
	end

	assign sts.busy     = (remain_q != '0);
	assign sts.pending  = valid_s1;
	assign sts.out_free = out_free;

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_byte    = last_q;
	assign frame_found  = found_q;
	assign frame_length = len_out_q;

endmodule

FILE: design/idle_line_frame_queue.sv
// idle_line_frame_queue: top level with request sequencer
// received bytes and idle events are taken back to back in the idle state
// a read holds in_stall until its descriptor is loaded and all bytes are issued;
// bytes pass the data ram and output register, one byte per cycle while out_stall
// is low; an empty read gives its single result once the previous tail has left
// arst_n clears positions, slot indices and count; ram contents are not cleared

module idle_line_frame_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ilfq_pkg::REQ_W-1:0]      req_type,
	input  logic [ilfq_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ilfq_pkg::BYTE_W-1:0]     out_byte,
	output logic                            last_byte,
	output logic                            frame_found,
	output logic [ilfq_pkg::FLEN_W-1:0]     frame_length
);

	ilfq_pkg::state_t      state_q;
	ilfq_pkg::state_t      state_d;
	ilfq_pkg::frame_cmd_t  fcmd;
	ilfq_pkg::stream_cmd_t scmd;
	ilfq_pkg::stream_sts_t ssts;
	ilfq_pkg::desc_t       desc;
	logic [ilfq_pkg::PTR_W-1:0] wr_pos;
	logic                  empty;
	logic                  take;

	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilfq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_stall       = 1'b1;
		fcmd           = '0;
		scmd.load      = 1'b0;
		scmd.empty_rsp = 1'b0;
		scmd.desc      = desc;
		case (state_q)
			ilfq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (take) begin
					case (ilfq_pkg::req_t'(req_type))
						ilfq_pkg::REQ_BYTE: fcmd.byte_we = 1'b1;
						ilfq_pkg::REQ_IDLE: fcmd.idle_ev = 1'b1;
						ilfq_pkg::REQ_READ: begin
							if (empty) begin
								state_d = ilfq_pkg::ST_EMPTY;
							end else begin
								fcmd.pop = 1'b1;
								state_d  = ilfq_pkg::ST_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			ilfq_pkg::ST_FETCH: begin
				scmd.load = 1'b1;
				state_d   = ilfq_pkg::ST_STREAM;
			end
			ilfq_pkg::ST_STREAM: begin
				if (!ssts.busy) begin
					state_d = ilfq_pkg::ST_IDLE;
				end
			end
			ilfq_pkg::ST_EMPTY: begin
				// wait for the previous frame's tail to leave before the reply
				if (!ssts.busy && !ssts.pending && ssts.out_free) begin
					scmd.empty_rsp = 1'b1;
					state_d        = ilfq_pkg::ST_IDLE;
				end
			end
			default: state_d = ilfq_pkg::ST_IDLE;
		endcase
	end

	ilfq_frame_ctl u_frame_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fcmd),
		.wr_pos (wr_pos),
		.desc   (desc),
		.empty  (empty)
	);

	ilfq_stream u_stream (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (fcmd.byte_we),
		.wr_addr      (wr_pos),
		.wr_data      (rx_byte),
		.cmd          (scmd),
		.sts          (ssts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.frame_found  (frame_found),
		.frame_length (frame_length)
	);

endmodule

FILE: design/ilfq_checker.sv
// ilfq_checker: port-level assertions for idle_line_frame_queue
// depends on ilfq_pkg; bound to the top level at the end of this file

module ilfq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [ilfq_pkg::REQ_W-1:0]      req_type,
	input logic [ilfq_pkg::BYTE_W-1:0]     rx_byte,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [ilfq_pkg::BYTE_W-1:0]     out_byte,
	input logic                            last_byte,
	input logic                            frame_found,
	input logic [ilfq_pkg::FLEN_W-1:0]     frame_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(last_byte) && $stable(frame_found) && $stable(frame_length))
		else $error("stalled result changed");

	// empty-queue reply is a single zeroed final result
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_found |-> last_byte && out_byte == '0 && frame_length == '0)
		else $error("malformed empty reply");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_found |-> frame_length != '0)
		else $error("frame with zero length");

	a_one_byte_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_found && frame_length == ilfq_pkg::FLEN_W'(1) |-> last_byte)
		else $error("single-byte frame not marked last");

	// a read transfer holds off the input side while it is served
	a_read_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == ilfq_pkg::REQ_READ |=> in_stall)
		else $error("input taken during read");

	logic unused_ok;
	assign unused_ok = ^rx_byte;

endmodule

bind idle_line_frame_queue ilfq_checker u_ilfq_checker (.*);

FILE: bench/testbench.sv
// testbench for idle_line_frame_queue: byte, idle and read transfers with random gaps
// keeps its own copy of the data ring and frame slots and checks every readout byte
// depends on ilfq_pkg and idle_line_frame_queue
`timescale 1ns / 1ps

module testbench;
	import ilfq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int ITEMS_TARGET   = 460;
	localparam int GAP_PCT        = 35;
	localparam int HOLDOFF_AFTER  = 60;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_SHOWN      = 10;

	typedef enum logic [1:0] {
		STEP_SEND,
		STEP_DRAIN,
		STEP_STEADY,
		STEP_GAPPY
	} step_t;

	typedef struct {
		step_t              kind;
		logic [REQ_W-1:0]   req;
		logic [BYTE_W-1:0]  data;
	} step_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              found;
		logic [FLEN_W-1:0] len;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = REQ_BYTE;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic last_byte;
	logic frame_found;
	logic [FLEN_W-1:0] frame_length;

	idle_line_frame_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.frame_found  (frame_found),
		.frame_length (frame_length)
	);

	always #1 clk = ~clk;

	// mirror of the block state
	logic [BYTE_W-1:0] ring_bytes [DATA_DEPTH];
	desc_t             slot_desc [FRAME_SLOTS];
	logic [PTR_W-1:0]  wr_pos = '0;
	logic [PTR_W-1:0]  frame_start = '0;
	logic [SLOT_W-1:0] slot_wr = '0;
	logic [SLOT_W-1:0] slot_rd = '0;
	logic [CNT_W-1:0]  slot_cnt = '0;

	step_item_t backlog [$];
	readout_t   readout_due [$];
	int planned = 0;
	int results_issued = 0;
	int results_taken = 0;
	int fault_count = 0;
	int holdoff_left = 0;
	int quiet_cycles = 0;
	bit holdoff_done = 1'b0;
	logic steady = 1'b0;
	logic steady_next;
	logic offer;
	step_item_t head;

	task automatic push_readout(input logic [BYTE_W-1:0] data, input logic last,
			input logic found, input logic [FLEN_W-1:0] len);
		readout_t r;
		r.data  = data;
		r.last  = last;
		r.found = found;
		r.len   = len;
		readout_due.push_back(r);
		results_issued++;
	endtask

	task automatic apply_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data);
		desc_t d;
		logic [PTR_W-1:0] pos;
		int n;
		case (req)
			REQ_BYTE: begin
				ring_bytes[wr_pos] = data;
				wr_pos = wr_pos + 1'b1;
			end
			REQ_IDLE: begin
				if (wr_pos != frame_start) begin
					// length wraps naturally at the ring width
					d.start = frame_start;
					d.len   = wr_pos - frame_start;
					slot_desc[slot_wr] = d;
					slot_wr = slot_wr + 1'b1;
					if (slot_cnt < FRAME_SLOTS)
						slot_cnt = slot_cnt + 1'b1;
					else
						slot_rd = slot_rd + 1'b1;
				end
				frame_start = wr_pos;
			end
			REQ_READ: begin
				if (slot_cnt == 0) begin
					push_readout('0, 1'b1, 1'b0, '0);
				end else begin
					d = slot_desc[slot_rd];
					slot_rd = slot_rd + 1'b1;
					slot_cnt = slot_cnt - 1'b1;
					pos = d.start;
					for (n = 0; n < d.len; n++) begin
						push_readout(ring_bytes[pos], n + 1 == d.len, 1'b1, d.len);
						pos = pos + 1'b1;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic log_fault(input string msg);
		if (fault_count < MAX_SHOWN)
			$display("%s", msg);
		fault_count++;
	endtask

	task automatic check_readout();
		readout_t want;
		if (readout_due.size() == 0) begin
			log_fault($sformatf("unexpected result: byte %02h last %0b found %0b len %0d",
				out_byte, last_byte, frame_found, frame_length));
		end else begin
			want = readout_due.pop_front();
			if (out_byte !== want.data || last_byte !== want.last ||
					frame_found !== want.found || frame_length !== want.len)
				log_fault($sformatf({"mismatch: want byte %02h last %0b found %0b len %0d,",
					" got byte %02h last %0b found %0b len %0d"},
					want.data, want.last, want.found, want.len,
					out_byte, last_byte, frame_found, frame_length));
		end
	endtask

	task automatic add_step(input step_t kind);
		step_item_t s;
		s.kind = kind;
		s.req  = REQ_BYTE;
		s.data = '0;
		backlog.push_back(s);
	endtask

	task automatic add_item(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data);
		step_item_t s;
		s.kind = STEP_SEND;
		s.req  = req;
		s.data = data;
		backlog.push_back(s);
		if (req != REQ_UNUSED)
			planned++;
	endtask

	task automatic add_frame(input int len);
		repeat (len) add_item(REQ_BYTE, BYTE_W'($urandom_range(255)));
		add_item(REQ_IDLE, BYTE_W'($urandom_range(255)));
	endtask

	// sender: one transfer per accepted cycle, markers at the head act between transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_request(req_type, rx_byte);
			end
			if (!in_valid || !in_stall) begin
				offer = 1'b0;
				steady_next = steady;
				while (backlog.size() > 0 && backlog[0].kind != STEP_SEND &&
						!(backlog[0].kind == STEP_DRAIN && results_issued != results_taken)) begin
					head = backlog.pop_front();
					if (head.kind == STEP_STEADY)
						steady_next = 1'b1;
					else if (head.kind == STEP_GAPPY)
						steady_next = 1'b0;
				end
				if (backlog.size() > 0 && backlog[0].kind == STEP_SEND &&
						(steady_next || $urandom_range(99) >= GAP_PCT)) begin
					head = backlog.pop_front();
					req_type <= head.req;
					rx_byte <= head.data;
					offer = 1'b1;
				end
				in_valid <= offer;
				steady <= steady_next;
			end
		end
	end

	// receiver: checks each transfer, stalls at random and holds off once for a long stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_readout();
				results_taken <= results_taken + 1;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else if (!holdoff_done && results_taken >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < GAP_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit steady_placed;
		bit gappy_placed;
		bit drain_placed;
		int pick;
		steady_placed = 1'b0;
		gappy_placed = 1'b0;
		drain_placed = 1'b0;

		// directed: empty read, idle with nothing new, unused code, short frames
		add_item(REQ_READ, 8'h00);
		add_item(REQ_IDLE, 8'hFF);
		add_item(REQ_UNUSED, 8'hFF);
		add_item(REQ_BYTE, 8'h00);
		add_item(REQ_BYTE, 8'hFF);
		add_item(REQ_UNUSED, 8'h00);
		add_item(REQ_BYTE, 8'hA5);
		add_item(REQ_IDLE, 8'h00);
		add_item(REQ_READ, 8'hFF);
		add_item(REQ_IDLE, 8'h5A);
		add_item(REQ_READ, 8'h00);
		add_item(REQ_BYTE, 8'h5A);
		add_item(REQ_IDLE, 8'h00);
		add_item(REQ_BYTE, 8'hC3);
		add_item(REQ_READ, 8'h00);
		add_item(REQ_IDLE, 8'h00);
		add_item(REQ_READ, 8'h00);
		add_item(REQ_READ, 8'h00);
		add_step(STEP_DRAIN);

		// longest frame, whole-ring overrun, one past it, then slot ring overflow
		add_frame(DATA_DEPTH - 1);
		add_item(REQ_READ, BYTE_W'($urandom_range(255)));
		add_frame(DATA_DEPTH);
		add_item(REQ_READ, BYTE_W'($urandom_range(255)));
		add_frame(DATA_DEPTH + 1);
		add_item(REQ_READ, BYTE_W'($urandom_range(255)));
		repeat (FRAME_SLOTS + 2) add_frame($urandom_range(1, 3));
		repeat (FRAME_SLOTS + 2) add_item(REQ_READ, BYTE_W'($urandom_range(255)));

		while (planned < ITEMS_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				add_frame($urandom_range(1, 8));
				if ($urandom_range(1))
					add_item(REQ_READ, BYTE_W'($urandom_range(255)));
			end else if (pick < 50) begin
				add_frame($urandom_range(9, DATA_DEPTH - 1));
			end else if (pick < 52) begin
				add_frame(DATA_DEPTH + $urandom_range(0, 2));
			end else if (pick < 56) begin
				repeat (FRAME_SLOTS + $urandom_range(0, 3)) add_frame($urandom_range(1, 4));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) add_item(REQ_READ, BYTE_W'($urandom_range(255)));
			end else begin
				add_item(REQ_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
			end
			if (!steady_placed && planned >= 200) begin
				add_step(STEP_STEADY);
				steady_placed = 1'b1;
			end
			if (!gappy_placed && planned >= 300) begin
				add_step(STEP_GAPPY);
				gappy_placed = 1'b1;
			end
			if (!drain_placed && planned >= 350) begin
				add_step(STEP_DRAIN);
				drain_placed = 1'b1;
			end
		end
		add_item(REQ_READ, BYTE_W'($urandom_range(255)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (results_issued != results_taken)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (readout_due.size() != 0)
			log_fault($sformatf("%0d results never arrived", readout_due.size()));

		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
